### rtl/look_at_view_matrix_assert.svh
// Assertion macros for the look-at view matrix block.
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LAV_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("look_at_view_matrix: assertion failed");

// Next-cycle implication.
`define LAV_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("look_at_view_matrix: assertion failed");

`endif

### rtl/lav_pkg.sv
// Shared types and constants of the look-at view matrix block.
`timescale 1ns / 1ps
package lav_pkg;

	localparam int SQ_STEPS = 31;                        // root bits, one per stage
	localparam int DV_STEPS = 31;                        // quotient bits, one per stage
	localparam int U_LAT    = 6 + SQ_STEPS + 1 + DV_STEPS + 1;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	typedef struct packed {
		logic signed [31:0] eye_x;
		logic signed [31:0] eye_y;
		logic signed [31:0] eye_z;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [31:0] up_x;
		logic signed [31:0] up_y;
		logic signed [31:0] up_z;
	} cam_t;

	typedef struct packed {
		logic signed [31:0] right_x;
		logic signed [31:0] right_y;
		logic signed [31:0] right_z;
		logic signed [31:0] upward_x;
		logic signed [31:0] upward_y;
		logic signed [31:0] upward_z;
		logic signed [31:0] forward_x;
		logic signed [31:0] forward_y;
		logic signed [31:0] forward_z;
		logic signed [31:0] shift_x;
		logic signed [31:0] shift_y;
		logic signed [31:0] shift_z;
	} view_t;

endpackage

### rtl/lav_if.sv
// Valid/ready channels for camera beats and view matrix beats.
`timescale 1ns / 1ps
interface lav_cam_if import lav_pkg::*; ();
	logic valid;
	logic ready;
	cam_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lav_view_if import lav_pkg::*; ();
	logic  valid;
	logic  ready;
	view_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/lav_unit3.sv
// Pipelined 3-vector normalizer: 64-bit signed in, Q2.30 unit vector out.
`timescale 1ns / 1ps
module lav_unit3 import lav_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic signed [63:0] in_v [3],
	output logic               out_vld,
	output logic signed [31:0] out_v [3]
);

	// front end: magnitude, leading one, alignment, squares
	logic        vld_u1, vld_u2, vld_u3, vld_u4, vld_u5, vld_u6;
	logic [2:0]  neg_u1, neg_u2, neg_u3, neg_u4, neg_u5, neg_u6;
	logic [63:0] mag_u1 [3];
	logic [63:0] mag_u2 [3];
	logic [63:0] mag_u3 [3];
	logic [3:0]  nz_u2;
	logic [3:0]  pos_u2 [4];
	logic [5:0]  top_u3;
	logic        zero_u3, zero_u4, zero_u5, zero_u6;
	logic [29:0] m_u4 [3];
	logic [29:0] m_u5 [3];
	logic [29:0] m_u6 [3];
	logic [59:0] sq_u5 [3];
	logic [61:0] sum_u6;

	logic [63:0] orv;
	logic [3:0]  nz_c;
	logic [3:0]  pos_c [4];
	logic [5:0]  top_c;
	logic [29:0] m_c [3];

	always_comb begin
		orv = mag_u1[0] | mag_u1[1] | mag_u1[2];
		for (int g = 0; g < 4; g++) begin
			nz_c[g]  = |orv[g*16 +: 16];
			pos_c[g] = '0;
			for (int b = 0; b < 16; b++) begin
				if (orv[g*16 + b])
					pos_c[g] = 4'(b);
			end
		end
	end

	always_comb begin
		top_c = '0;
		for (int g = 0; g < 4; g++) begin
			if (nz_u2[g])
				top_c = {2'(g), pos_u2[g]};
		end
	end

	// bring the top set bit to bit 29
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (top_u3 > 6'd29)
				m_c[j] = 30'(mag_u3[j] >> (top_u3 - 6'd29));
			else
				m_c[j] = 30'(mag_u3[j] << (6'd29 - top_u3));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_u1 <= 1'b0;
			vld_u2 <= 1'b0;
			vld_u3 <= 1'b0;
			vld_u4 <= 1'b0;
			vld_u5 <= 1'b0;
			vld_u6 <= 1'b0;
		end else if (en) begin
			vld_u1 <= in_vld;
			vld_u2 <= vld_u1;
			vld_u3 <= vld_u2;
			vld_u4 <= vld_u3;
			vld_u5 <= vld_u4;
			vld_u6 <= vld_u5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				neg_u1[j] <= in_v[j][63];
				mag_u1[j] <= in_v[j][63] ? 64'(-in_v[j]) : 64'(in_v[j]);
				sq_u5[j]  <= 60'(m_u4[j] * m_u4[j]);
			end
			mag_u2  <= mag_u1;
			neg_u2  <= neg_u1;
			nz_u2   <= nz_c;
			pos_u2  <= pos_c;
			mag_u3  <= mag_u2;
			neg_u3  <= neg_u2;
			top_u3  <= top_c;
			zero_u3 <= ~|nz_u2;
			m_u4    <= m_c;
			neg_u4  <= neg_u3;
			zero_u4 <= zero_u3;
			m_u5    <= m_u4;
			neg_u5  <= neg_u4;
			zero_u5 <= zero_u4;
			sum_u6  <= 62'(sq_u5[0]) + 62'(sq_u5[1]) + 62'(sq_u5[2]);
			m_u6    <= m_u5;
			neg_u6  <= neg_u5;
			zero_u6 <= zero_u5;
		end
	end

	// square root, one root bit per stage
	logic        sq_vld_s  [SQ_STEPS];
	logic [31:0] sq_rem_s  [SQ_STEPS];
	logic [30:0] sq_root_s [SQ_STEPS];
	logic [61:0] sq_sum_s  [SQ_STEPS];
	logic [29:0] sq_m_s    [SQ_STEPS][3];
	logic [2:0]  sq_neg_s  [SQ_STEPS];
	logic        sq_zero_s [SQ_STEPS];

	genvar k;
	for (k = 0; k < SQ_STEPS; k++) begin : g_sq
		logic        vld_p;
		logic [31:0] rem_p;
		logic [30:0] root_p;
		logic [61:0] sum_p;
		logic [29:0] m_p [3];
		logic [2:0]  neg_p;
		logic        zero_p;
		logic [33:0] r_in;
		logic [33:0] t_in;

		if (k == 0) begin : g_first
			assign vld_p  = vld_u6;
			assign rem_p  = '0;
			assign root_p = '0;
			assign sum_p  = sum_u6;
			assign m_p    = m_u6;
			assign neg_p  = neg_u6;
			assign zero_p = zero_u6;
		end else begin : g_next
			assign vld_p  = sq_vld_s[k-1];
			assign rem_p  = sq_rem_s[k-1];
			assign root_p = sq_root_s[k-1];
			assign sum_p  = sq_sum_s[k-1];
			assign m_p    = sq_m_s[k-1];
			assign neg_p  = sq_neg_s[k-1];
			assign zero_p = sq_zero_s[k-1];
		end

		assign r_in = {rem_p, sum_p[61-2*k -: 2]};
		assign t_in = {1'b0, root_p, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_vld_s[k] <= 1'b0;
			else if (en)
				sq_vld_s[k] <= vld_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (r_in >= t_in) begin
					sq_rem_s[k]  <= 32'(r_in - t_in);
					sq_root_s[k] <= {root_p[29:0], 1'b1};
				end else begin
					sq_rem_s[k]  <= 32'(r_in);
					sq_root_s[k] <= {root_p[29:0], 1'b0};
				end
				sq_sum_s[k]  <= sum_p;
				sq_m_s[k]    <= m_p;
				sq_neg_s[k]  <= neg_p;
				sq_zero_s[k] <= zero_p;
			end
		end
	end

	// divider setup: numerator m * 2^30 + len / 2
	logic        vld_d0;
	logic [30:0] len_d0;
	logic [30:0] rem_d0 [3];
	logic [30:0] lo_d0  [3];
	logic [2:0]  neg_d0;
	logic        zero_d0;
	logic [60:0] num_c [3];

	always_comb begin
		for (int j = 0; j < 3; j++)
			num_c[j] = {1'b0, sq_m_s[SQ_STEPS-1][j], 30'b0}
				+ {31'b0, sq_root_s[SQ_STEPS-1][30:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_d0 <= 1'b0;
		else if (en)
			vld_d0 <= sq_vld_s[SQ_STEPS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				rem_d0[j] <= {1'b0, num_c[j][60:31]};
				lo_d0[j]  <= num_c[j][30:0];
			end
			len_d0  <= sq_root_s[SQ_STEPS-1];
			neg_d0  <= sq_neg_s[SQ_STEPS-1];
			zero_d0 <= sq_zero_s[SQ_STEPS-1];
		end
	end

	// restoring divide, one quotient bit per stage, three lanes
	logic        dv_vld_s  [DV_STEPS];
	logic [30:0] dv_rem_s  [DV_STEPS][3];
	logic [30:0] dv_q_s    [DV_STEPS][3];
	logic [30:0] dv_lo_s   [DV_STEPS][3];
	logic [30:0] dv_len_s  [DV_STEPS];
	logic [2:0]  dv_neg_s  [DV_STEPS];
	logic        dv_zero_s [DV_STEPS];

	for (k = 0; k < DV_STEPS; k++) begin : g_dv
		logic        vld_p;
		logic [30:0] rem_p [3];
		logic [30:0] q_p   [3];
		logic [30:0] lo_p  [3];
		logic [30:0] len_p;
		logic [2:0]  neg_p;
		logic        zero_p;
		logic [31:0] r_in  [3];

		if (k == 0) begin : g_first
			assign vld_p  = vld_d0;
			assign rem_p  = rem_d0;
			assign q_p    = '{default: '0};
			assign lo_p   = lo_d0;
			assign len_p  = len_d0;
			assign neg_p  = neg_d0;
			assign zero_p = zero_d0;
		end else begin : g_next
			assign vld_p  = dv_vld_s[k-1];
			assign rem_p  = dv_rem_s[k-1];
			assign q_p    = dv_q_s[k-1];
			assign lo_p   = dv_lo_s[k-1];
			assign len_p  = dv_len_s[k-1];
			assign neg_p  = dv_neg_s[k-1];
			assign zero_p = dv_zero_s[k-1];
		end

		always_comb begin
			for (int j = 0; j < 3; j++)
				r_in[j] = {rem_p[j], lo_p[j][30-k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_vld_s[k] <= 1'b0;
			else if (en)
				dv_vld_s[k] <= vld_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					if (r_in[j] >= {1'b0, len_p}) begin
						dv_rem_s[k][j] <= 31'(r_in[j] - {1'b0, len_p});
						dv_q_s[k][j]   <= {q_p[j][29:0], 1'b1};
					end else begin
						dv_rem_s[k][j] <= 31'(r_in[j]);
						dv_q_s[k][j]   <= {q_p[j][29:0], 1'b0};
					end
				end
				dv_lo_s[k]   <= lo_p;
				dv_len_s[k]  <= len_p;
				dv_neg_s[k]  <= neg_p;
				dv_zero_s[k] <= zero_p;
			end
		end
	end

	// clamp to one, sign back on; a zero vector gives zero
	logic [30:0] qc [3];

	always_comb begin
		for (int j = 0; j < 3; j++)
			qc[j] = (dv_q_s[DV_STEPS-1][j] > ONE_Q30) ? ONE_Q30 : dv_q_s[DV_STEPS-1][j];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld <= 1'b0;
		else if (en)
			out_vld <= dv_vld_s[DV_STEPS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				if (dv_zero_s[DV_STEPS-1])
					out_v[j] <= '0;
				else if (dv_neg_s[DV_STEPS-1][j])
					out_v[j] <= -$signed({1'b0, qc[j]});
				else
					out_v[j] <= $signed({1'b0, qc[j]});
			end
		end
	end

endmodule

### rtl/look_at_view_matrix.sv
// Top level: left-handed look-at view matrix pipeline, Q16.16 in, Q2.30 axes out.
//
//   channel   dir   handshake       beat
//   cam       in    valid/ready     eye, target, up (Q16.16)
//   view      out   valid/ready     right, upward, forward (Q2.30), shift (Q16.16)
//
// One camera beat per cycle while view is not stalled. Stages: input stage, two 70-stage
// normalizers of one root bit and one quotient bit per stage, cross and dot stages.
// arst_n clears the valid bits only; the datapath registers are not reset.
// A stall on view freezes the whole pipe; cam.ready drops only while the
// output register holds a beat that is not taken.
`timescale 1ns / 1ps
`include "look_at_view_matrix_assert.svh"
module look_at_view_matrix import lav_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lav_cam_if.sink    cam,
	lav_view_if.source view
);

	function automatic logic signed [63:0] sx64(input logic signed [31:0] a);
		return {{32{a[31]}}, a};
	endfunction

	// Q4.60 to Q2.30, half away from zero, clamped to one
	function automatic logic signed [31:0] rnd_q30(input logic signed [63:0] v);
		logic [63:0] m;
		logic [33:0] r;
		m = v[63] ? 64'(-v) : 64'(v);
		r = 34'((m + 64'h2000_0000) >> 30);
		if (r > 34'(ONE_Q30))
			r = 34'(ONE_Q30);
		return v[63] ? -$signed(32'(r)) : $signed(32'(r));
	endfunction

	// negated Q18.46 dot to Q16.16, half away from zero, saturated
	function automatic logic signed [31:0] neg_sat(input logic signed [63:0] d);
		logic        n;
		logic [63:0] m;
		logic [34:0] r;
		logic signed [31:0] res;
		n = (d > 0);
		m = d[63] ? 64'(-d) : 64'(d);
		r = 35'((m + 64'h2000_0000) >> 30);
		if (n)
			res = (r > 35'h0_8000_0000) ? 32'sh8000_0000 : -$signed(32'(r));
		else
			res = (r > 35'h0_7fff_ffff) ? 32'sh7fff_ffff : $signed(32'(r));
		return res;
	endfunction

	logic en;
	assign en        = !view.valid || view.ready;
	assign cam.ready = en;

	// input stage
	logic               vld_s1;
	logic signed [31:0] eye_s1 [3];
	logic signed [31:0] up_s1  [3];
	logic signed [63:0] dir_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= cam.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eye_s1[0] <= cam.data.eye_x;
			eye_s1[1] <= cam.data.eye_y;
			eye_s1[2] <= cam.data.eye_z;
			up_s1[0]  <= cam.data.up_x;
			up_s1[1]  <= cam.data.up_y;
			up_s1[2]  <= cam.data.up_z;
			dir_s1[0] <= sx64(cam.data.target_x) - sx64(cam.data.eye_x);
			dir_s1[1] <= sx64(cam.data.target_y) - sx64(cam.data.eye_y);
			dir_s1[2] <= sx64(cam.data.target_z) - sx64(cam.data.eye_z);
		end
	end

	// forward axis
	logic               vld_a;
	logic signed [31:0] fwd_a [3];

	lav_unit3 u_fwd (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s1),
		.in_v    (dir_s1),
		.out_vld (vld_a),
		.out_v   (fwd_a)
	);

	logic signed [31:0] eye_da [U_LAT][3];
	logic signed [31:0] up_da  [U_LAT][3];

	always_ff @(posedge clk) begin
		if (en) begin
			eye_da[0] <= eye_s1;
			up_da[0]  <= up_s1;
			for (int i = 1; i < U_LAT; i++) begin
				eye_da[i] <= eye_da[i-1];
				up_da[i]  <= up_da[i-1];
			end
		end
	end

	// up x forward
	logic               vld_c1, vld_c2;
	logic signed [63:0] prd_c1 [6];
	logic signed [63:0] crs_c2 [3];
	logic signed [31:0] eye_c1 [3];
	logic signed [31:0] eye_c2 [3];
	logic signed [31:0] fwd_c1 [3];
	logic signed [31:0] fwd_c2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c1 <= 1'b0;
			vld_c2 <= 1'b0;
		end else if (en) begin
			vld_c1 <= vld_a;
			vld_c2 <= vld_c1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prd_c1[0] <= up_da[U_LAT-1][1] * fwd_a[2];
			prd_c1[1] <= up_da[U_LAT-1][2] * fwd_a[1];
			prd_c1[2] <= up_da[U_LAT-1][2] * fwd_a[0];
			prd_c1[3] <= up_da[U_LAT-1][0] * fwd_a[2];
			prd_c1[4] <= up_da[U_LAT-1][0] * fwd_a[1];
			prd_c1[5] <= up_da[U_LAT-1][1] * fwd_a[0];
			eye_c1    <= eye_da[U_LAT-1];
			fwd_c1    <= fwd_a;
			crs_c2[0] <= prd_c1[0] - prd_c1[1];
			crs_c2[1] <= prd_c1[2] - prd_c1[3];
			crs_c2[2] <= prd_c1[4] - prd_c1[5];
			eye_c2    <= eye_c1;
			fwd_c2    <= fwd_c1;
		end
	end

	// right axis
	logic               vld_b;
	logic signed [31:0] rgt_b [3];

	lav_unit3 u_rgt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_c2),
		.in_v    (crs_c2),
		.out_vld (vld_b),
		.out_v   (rgt_b)
	);

	logic signed [31:0] eye_db [U_LAT][3];
	logic signed [31:0] fwd_db [U_LAT][3];

	always_ff @(posedge clk) begin
		if (en) begin
			eye_db[0] <= eye_c2;
			fwd_db[0] <= fwd_c2;
			for (int i = 1; i < U_LAT; i++) begin
				eye_db[i] <= eye_db[i-1];
				fwd_db[i] <= fwd_db[i-1];
			end
		end
	end

	// true up = forward x right
	logic               vld_p1, vld_p2, vld_p3;
	logic signed [63:0] prd_p1 [6];
	logic signed [63:0] dif_p2 [3];
	logic signed [31:0] upw_p3 [3];
	logic signed [31:0] eye_p1 [3];
	logic signed [31:0] eye_p2 [3];
	logic signed [31:0] eye_p3 [3];
	logic signed [31:0] fwd_p1 [3];
	logic signed [31:0] fwd_p2 [3];
	logic signed [31:0] fwd_p3 [3];
	logic signed [31:0] rgt_p1 [3];
	logic signed [31:0] rgt_p2 [3];
	logic signed [31:0] rgt_p3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1 <= 1'b0;
			vld_p2 <= 1'b0;
			vld_p3 <= 1'b0;
		end else if (en) begin
			vld_p1 <= vld_b;
			vld_p2 <= vld_p1;
			vld_p3 <= vld_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prd_p1[0] <= fwd_db[U_LAT-1][1] * rgt_b[2];
			prd_p1[1] <= fwd_db[U_LAT-1][2] * rgt_b[1];
			prd_p1[2] <= fwd_db[U_LAT-1][2] * rgt_b[0];
			prd_p1[3] <= fwd_db[U_LAT-1][0] * rgt_b[2];
			prd_p1[4] <= fwd_db[U_LAT-1][0] * rgt_b[1];
			prd_p1[5] <= fwd_db[U_LAT-1][1] * rgt_b[0];
			eye_p1    <= eye_db[U_LAT-1];
			fwd_p1    <= fwd_db[U_LAT-1];
			rgt_p1    <= rgt_b;
			dif_p2[0] <= prd_p1[0] - prd_p1[1];
			dif_p2[1] <= prd_p1[2] - prd_p1[3];
			dif_p2[2] <= prd_p1[4] - prd_p1[5];
			eye_p2    <= eye_p1;
			fwd_p2    <= fwd_p1;
			rgt_p2    <= rgt_p1;
			for (int j = 0; j < 3; j++)
				upw_p3[j] <= rnd_q30(dif_p2[j]);
			eye_p3    <= eye_p2;
			fwd_p3    <= fwd_p2;
			rgt_p3    <= rgt_p2;
		end
	end

	// translation: eye dot each axis, axis 0 right, 1 up, 2 forward
	logic               vld_d1, vld_d2;
	logic signed [63:0] dp_d1  [3][3];
	logic signed [63:0] sum_d2 [3];
	logic signed [31:0] rgt_d1 [3];
	logic signed [31:0] rgt_d2 [3];
	logic signed [31:0] upw_d1 [3];
	logic signed [31:0] upw_d2 [3];
	logic signed [31:0] fwd_d1 [3];
	logic signed [31:0] fwd_d2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d1     <= 1'b0;
			vld_d2     <= 1'b0;
			view.valid <= 1'b0;
		end else if (en) begin
			vld_d1     <= vld_p3;
			vld_d2     <= vld_d1;
			view.valid <= vld_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dp_d1[0][i] <= eye_p3[i] * rgt_p3[i];
				dp_d1[1][i] <= eye_p3[i] * upw_p3[i];
				dp_d1[2][i] <= eye_p3[i] * fwd_p3[i];
				sum_d2[i]   <= dp_d1[i][0] + dp_d1[i][1] + dp_d1[i][2];
			end
			rgt_d1 <= rgt_p3;
			upw_d1 <= upw_p3;
			fwd_d1 <= fwd_p3;
			rgt_d2 <= rgt_d1;
			upw_d2 <= upw_d1;
			fwd_d2 <= fwd_d1;
			view.data.right_x   <= rgt_d2[0];
			view.data.right_y   <= rgt_d2[1];
			view.data.right_z   <= rgt_d2[2];
			view.data.upward_x  <= upw_d2[0];
			view.data.upward_y  <= upw_d2[1];
			view.data.upward_z  <= upw_d2[2];
			view.data.forward_x <= fwd_d2[0];
			view.data.forward_y <= fwd_d2[1];
			view.data.forward_z <= fwd_d2[2];
			view.data.shift_x   <= neg_sat(sum_d2[0]);
			view.data.shift_y   <= neg_sat(sum_d2[1]);
			view.data.shift_z   <= neg_sat(sum_d2[2]);
		end
	end

	// output beat checks
	logic fwd_in_rng, fwd_nil, rgt_nil, upw_nil;
	assign fwd_in_rng = (view.data.forward_x <= 32'sh4000_0000)
		&& (view.data.forward_x >= -32'sh4000_0000);
	assign fwd_nil = (view.data.forward_x == 0) && (view.data.forward_y == 0)
		&& (view.data.forward_z == 0);
	assign rgt_nil = (view.data.right_x == 0) && (view.data.right_y == 0)
		&& (view.data.right_z == 0);
	assign upw_nil = (view.data.upward_x == 0) && (view.data.upward_y == 0)
		&& (view.data.upward_z == 0);

	// the forward axis x component never leaves [-1, 1]
	`LAV_ASSERT_NOW(a_fwd_range, view.valid, fwd_in_rng)
	// no forward axis means no right axis
	`LAV_ASSERT_NOW(a_fwd_zero, view.valid && fwd_nil, rgt_nil)
	// no right axis means no true up and no x/y translation
	`LAV_ASSERT_NOW(a_rgt_zero, view.valid && rgt_nil, upw_nil && view.data.shift_x == 0 && view.data.shift_y == 0)
	// a stalled output beat is not overwritten by the pipe behind it
	`LAV_ASSERT_NEXT(a_stall_freeze, view.valid && !view.ready, $stable(view.data.shift_z) && $stable(view.data.right_x))

endmodule

### tb/tb_look_at_view_matrix.sv
// Self-checking testbench of the look-at view matrix pipeline.
`timescale 1ns / 1ps
module tb_look_at_view_matrix;
	import lav_pkg::*;

	localparam int LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #10 clk = ~clk;

	lav_cam_if  cam ();
	lav_view_if view ();

	look_at_view_matrix DUT (.clk(clk), .arst_n(arst_n), .cam(cam), .view(view));

	cam_t  pending_cams[$];
	view_t expected_views[$];
	int    mismatches = 0;
	int    cycles = 0;
	bit    calm = 0;          // no idling in the last part
	bit    hold_sink = 0;     // long receiver hold-off
	bit    hold_src = 0;      // sender pause until drained

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int sh);
		logic [63:0] m;
		m = (mag(v) + (64'd1 << (sh - 1))) >> sh;
		return v < 0 ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [63:0] sqrt_floor(input logic [63:0] s);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s = s - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	typedef logic signed [63:0] vec3_t [3];

	function automatic vec3_t unit_vec(input vec3_t v);
		vec3_t o;
		logic [63:0] m [3];
		logic [63:0] top, s, len, q;
		int p;
		top = 0;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = mag(v[i]);
			if (m[i] > top) top = m[i];
		end
		if (top == 0) begin
			o[0] = 0; o[1] = 0; o[2] = 0;
			return o;
		end
		p = 0;
		while (p < 63 && (top >> (p + 1)) != 0) p++;
		for (int i = 0; i < 3; i++) begin
			if (p > 29) m[i] = m[i] >> (p - 29);
			else if (p < 29) m[i] = m[i] << (29 - p);
			s = s + m[i] * m[i];
		end
		len = sqrt_floor(s);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << 30) + (len >> 1)) / len;
			if (q > 64'd1073741824) q = 64'd1073741824;
			o[i] = v[i] < 0 ? -$signed(q) : $signed(q);
		end
		return o;
	endfunction

	function automatic logic signed [63:0] clamp_unit(input logic signed [63:0] v);
		if (v > 64'sd1073741824) return 64'sd1073741824;
		if (v < -64'sd1073741824) return -64'sd1073741824;
		return v;
	endfunction

	function automatic logic signed [31:0] eye_shift(input vec3_t e, input vec3_t a);
		logic signed [63:0] d;
		d = e[0] * a[0] + e[1] * a[1] + e[2] * a[2];
		d = rnd_shift(-d, 30);
		if (d > 64'sd2147483647) d = 64'sd2147483647;
		if (d < -64'sd2147483648) d = -64'sd2147483648;
		return d[31:0];
	endfunction

	function automatic view_t view_of(input cam_t c);
		view_t r;
		vec3_t eye, up, dir, fwd, crs, rgt, upw;
		eye[0] = c.eye_x; eye[1] = c.eye_y; eye[2] = c.eye_z;
		up[0] = c.up_x; up[1] = c.up_y; up[2] = c.up_z;
		dir[0] = 64'(c.target_x) - eye[0];
		dir[1] = 64'(c.target_y) - eye[1];
		dir[2] = 64'(c.target_z) - eye[2];
		fwd = unit_vec(dir);
		crs[0] = up[1] * fwd[2] - up[2] * fwd[1];
		crs[1] = up[2] * fwd[0] - up[0] * fwd[2];
		crs[2] = up[0] * fwd[1] - up[1] * fwd[0];
		rgt = unit_vec(crs);
		upw[0] = clamp_unit(rnd_shift(fwd[1] * rgt[2] - fwd[2] * rgt[1], 30));
		upw[1] = clamp_unit(rnd_shift(fwd[2] * rgt[0] - fwd[0] * rgt[2], 30));
		upw[2] = clamp_unit(rnd_shift(fwd[0] * rgt[1] - fwd[1] * rgt[0], 30));
		r.right_x = rgt[0][31:0]; r.right_y = rgt[1][31:0]; r.right_z = rgt[2][31:0];
		r.upward_x = upw[0][31:0]; r.upward_y = upw[1][31:0]; r.upward_z = upw[2][31:0];
		r.forward_x = fwd[0][31:0]; r.forward_y = fwd[1][31:0]; r.forward_z = fwd[2][31:0];
		r.shift_x = eye_shift(eye, rgt);
		r.shift_y = eye_shift(eye, upw);
		r.shift_z = eye_shift(eye, fwd);
		return r;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
			2: return 32'($signed($urandom_range(0, 2000)) - 1000);
			3: return {$urandom_range(0, 1) ? 2'b11 : 2'b00, 30'($urandom)};
			4: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
		endcase
	endfunction

	function automatic cam_t rand_cam();
		cam_t c;
		c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom};
		c.eye_x = rand_coord(); c.eye_y = rand_coord(); c.eye_z = rand_coord();
		c.target_x = rand_coord(); c.target_y = rand_coord(); c.target_z = rand_coord();
		c.up_x = rand_coord(); c.up_y = rand_coord(); c.up_z = rand_coord();
		case ($urandom_range(0, 9))
			0: begin c.target_x = c.eye_x; c.target_y = c.eye_y; c.target_z = c.eye_z; end
			1: begin c.up_x = 0; c.up_y = 0; c.up_z = 0; end
			2: begin
				c.up_x = c.target_x - c.eye_x;
				c.up_y = c.target_y - c.eye_y;
				c.up_z = c.target_z - c.eye_z;
			end
			3: begin c.up_x = 0; c.up_y = 32'h0001_0000; c.up_z = 0; end
			default: ;
		endcase
		return c;
	endfunction

	function automatic cam_t mk_cam(input logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
		cam_t c;
		c.eye_x = ex; c.eye_y = ey; c.eye_z = ez;
		c.target_x = tx; c.target_y = ty; c.target_z = tz;
		c.up_x = ux; c.up_y = uy; c.up_z = uz;
		return c;
	endfunction

	// Driver.
	int src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam.valid <= 1'b0;
			cam.data <= '0;
		end else begin
			if (!cam.valid || cam.ready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					cam.valid <= 1'b0;
				end else if (!hold_src && pending_cams.size() > 0 &&
						!(cam.valid && cam.ready && pending_cams.size() == 0)) begin
					if (!calm && $urandom_range(0, 9) == 0) begin
						src_gap <= $urandom_range(1, 8) - 1;
						cam.valid <= 1'b0;
					end else begin
						cam.data <= pending_cams[0];
						cam.valid <= 1'b1;
						expected_views.push_back(view_of(pending_cams[0]));
						pending_cams.pop_front();
					end
				end else begin
					cam.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and receiver stalls.
	int snk_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		view_t got, want;
		if (!arst_n) begin
			view.ready <= 1'b0;
		end else begin
			cycles <= cycles + 1;
			if (view.valid && view.ready) begin
				got = view.data;
				if (expected_views.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("view beat with nothing expected");
				end else begin
					want = expected_views.pop_front();
					if (got !== want) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch: expected %h got %h", want, got);
					end
				end
			end
			if (hold_sink) begin
				view.ready <= 1'b0;
			end else if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				view.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				snk_gap <= $urandom_range(1, 8) - 1;
				view.ready <= 1'b0;
			end else begin
				view.ready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off, counted in cycles, while the first batch is still flowing.
	initial begin
		wait (cycles == 300);
		hold_sink = 1;
		repeat (400) @(posedge clk);
		hold_sink = 0;
	end

	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		pending_cams.push_back(mk_cam(0, 0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0));
		pending_cams.push_back(mk_cam(5, 6, 7, 5, 6, 7, 0, 32'h10000, 0));
		pending_cams.push_back(mk_cam(0, 0, 0, 32'h10000, 0, 0, 0, 0, 0));
		pending_cams.push_back(mk_cam(0, 0, 0, 0, 32'h10000, 0, 0, 32'h30000, 0));
		pending_cams.push_back(mk_cam(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 32'h80000000));
		pending_cams.push_back(mk_cam(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0));
		pending_cams.push_back(mk_cam(32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 32'h7ffffffe, 32'hffffffff, 32'hffffffff, 1));
		pending_cams.push_back(mk_cam(32'h40000000, 32'h40000000, 32'h40000000,
			32'hc0000000, 32'hc0000000, 32'hc0000000, 0, 32'h10000, 0));
		pending_cams.push_back(mk_cam(1, 0, 0, 0, 0, 0, 0, 1, 0));
		pending_cams.push_back(mk_cam(32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'h7fffffff, 0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
		for (int i = 0; i < 10; i++) pending_cams.push_back(rand_cam());
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < 600; i++) pending_cams.push_back(rand_cam());
		wait (pending_cams.size() == 0);
		hold_src = 1;
		wait (expected_views.size() == 0);
		@(posedge clk);
		hold_src = 0;
		for (int i = 0; i < 450; i++) pending_cams.push_back(rand_cam());
		wait (pending_cams.size() == 0);
		calm = 1;
		for (int i = 0; i < 200; i++) pending_cams.push_back(rand_cam());
		wait (pending_cams.size() == 0);
		wait (expected_views.size() == 0);
		repeat (U_LAT + 20) @(posedge clk);
		if (mismatches == 0 && expected_views.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
